/* hw/rtl/sms_pkg.sv */
// Shared types and constants for the series statistics block.
`default_nettype none

package sms_pkg;

  // Field and accumulator widths
  localparam int SAMPLE_W  = 24;
  localparam int POS_W     = 16;
  localparam int CNT_W     = 17;
  localparam int SUM_W     = 40;
  localparam int SQ_W      = 63;
  localparam int MAX_COUNT = 65536;

  // Iterative unit sizes
  localparam int DIV_W      = 64;
  localparam int REM_W      = CNT_W;
  localparam int MUL_STEPS  = SAMPLE_W;
  localparam int DIV_STEPS  = DIV_W;
  localparam int ROOT_W     = DIV_W / 2;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int ROOT_REM_W = ROOT_W + 2;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_MEAN_LOAD,
    OP_MEAN_STEP,
    OP_MUL_LOAD,
    OP_MUL_STEP,
    OP_VAR_LOAD,
    OP_VAR_STEP,
    OP_ROOT_LOAD,
    OP_ROOT_STEP,
    OP_FINISH
  } dp_op_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_MEAN_LOAD,
    ST_MEAN,
    ST_MUL_LOAD,
    ST_MUL,
    ST_VAR_LOAD,
    ST_VAR,
    ST_ROOT_LOAD,
    ST_ROOT,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic   take;
    dp_op_t op;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_pend;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

/* hw/rtl/series_mean_stddev_min_max.sv */
// Top level of the series statistics block: controller plus datapath.
`default_nettype none

// Takes one signed sample (8 fraction bits) per cycle while sample_ready is
// high; the item with last set closes the series. After that item is
// accepted, the block folds it in and then runs the shared shift divider
// (64 steps for the mean, 64 for the variance), the 24-step shift-add product
// and the 32-step root, one bit or digit per cycle, each phase after its own
// load step, and finally loads the result and raises result_valid.
// If an earlier result is still waiting to be taken, the load waits with it.
// sample_ready stays low over that stretch and returns the cycle after the
// result is loaded; a new series may then run while the previous result waits
// to be taken. Past 65536 samples further items are dropped and overflow is
// reported.
module series_mean_stddev_min_max import sms_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sample_valid,
  output logic                       sample_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       last,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic signed [SAMPLE_W-1:0] mean_value,
  output logic        [SAMPLE_W-1:0] std_dev,
  output logic signed [SAMPLE_W-1:0] max_value,
  output logic        [POS_W-1:0]    max_position,
  output logic signed [SAMPLE_W-1:0] min_value,
  output logic        [POS_W-1:0]    min_position,
  output logic        [CNT_W-1:0]    sample_count,
  output logic                       overflow
);

  cmd_t  cmd;
  stat_t stat;

  assign sample_ready = cmd.take;

  // Sequence the phases
  sms_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // Accumulate and compute
  sms_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .sample_valid (sample_valid),
    .sample       (sample),
    .last         (last),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .mean_value   (mean_value),
    .std_dev      (std_dev),
    .max_value    (max_value),
    .max_position (max_position),
    .min_value    (min_value),
    .min_position (min_position),
    .sample_count (sample_count),
    .overflow     (overflow)
  );

endmodule

`default_nettype wire

/* hw/rtl/sms_ctrl.sv */
// Controller state machine that sequences accumulation and the final math.
`default_nettype none

module sms_ctrl import sms_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t            state, state_next;
  logic [STEP_W-1:0] step_cnt, step_cnt_next;

  // Hold state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_ACCUM;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  // Advance through the phases, one datapath operation per cycle; the finish waits while an earlier result is untaken
  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd.take      = 1'b0;
    cmd.op        = OP_NONE;
    unique case (state)
      ST_ACCUM: begin
        cmd.take = !stat.last_pend;
        if (stat.last_pend) begin
          state_next = ST_MEAN_LOAD;
        end
      end
      ST_MEAN_LOAD: begin
        cmd.op        = OP_MEAN_LOAD;
        step_cnt_next = STEP_W'(DIV_STEPS - 1);
        state_next    = ST_MEAN;
      end
      ST_MEAN: begin
        cmd.op        = OP_MEAN_STEP;
        step_cnt_next = step_cnt - 1'b1;
        if (step_cnt == '0) begin
          state_next = ST_MUL_LOAD;
        end
      end
      ST_MUL_LOAD: begin
        cmd.op        = OP_MUL_LOAD;
        step_cnt_next = STEP_W'(MUL_STEPS - 1);
        state_next    = ST_MUL;
      end
      ST_MUL: begin
        cmd.op        = OP_MUL_STEP;
        step_cnt_next = step_cnt - 1'b1;
        if (step_cnt == '0) begin
          state_next = ST_VAR_LOAD;
        end
      end
      ST_VAR_LOAD: begin
        cmd.op        = OP_VAR_LOAD;
        step_cnt_next = STEP_W'(DIV_STEPS - 1);
        state_next    = ST_VAR;
      end
      ST_VAR: begin
        cmd.op        = OP_VAR_STEP;
        step_cnt_next = step_cnt - 1'b1;
        if (step_cnt == '0) begin
          state_next = ST_ROOT_LOAD;
        end
      end
      ST_ROOT_LOAD: begin
        cmd.op        = OP_ROOT_LOAD;
        step_cnt_next = STEP_W'(ROOT_STEPS - 1);
        state_next    = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.op        = OP_ROOT_STEP;
        step_cnt_next = step_cnt - 1'b1;
        if (step_cnt == '0) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.op     = OP_FINISH;
          state_next = ST_ACCUM;
        end
      end
      default: begin
        state_next = ST_ACCUM;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/sms_dp.sv */
// Datapath: accumulators, extreme tracking, shift divider, multiplier and root.
`default_nettype none

module sms_dp import sms_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       cmd,
  output stat_t                      stat,
  input  logic                       sample_valid,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       last,
  input  logic                       result_ready,
  output logic                       result_valid,
  output logic signed [SAMPLE_W-1:0] mean_value,
  output logic        [SAMPLE_W-1:0] std_dev,
  output logic signed [SAMPLE_W-1:0] max_value,
  output logic        [POS_W-1:0]    max_position,
  output logic signed [SAMPLE_W-1:0] min_value,
  output logic        [POS_W-1:0]    min_position,
  output logic        [CNT_W-1:0]    sample_count,
  output logic                       overflow
);

  // Input stage
  logic                       pend;
  logic signed [SAMPLE_W-1:0] pend_sample;
  logic                       pend_last;

  // Series accumulators
  logic        [CNT_W-1:0]    count;
  logic signed [SUM_W-1:0]    running_sum;
  logic        [SQ_W-1:0]     running_sum_squares;
  logic signed [SAMPLE_W-1:0] best_max, best_min;
  logic        [POS_W-1:0]    best_max_pos, best_min_pos;
  logic                       overflow_seen;

  // Final math registers
  logic [DIV_W-1:0]      div_q;
  logic [REM_W-1:0]      div_rem;
  logic [SAMPLE_W-1:0]   mul_a;
  logic [DIV_W-1:0]      mul_b;
  logic [DIV_W-1:0]      mul_acc;
  logic [SAMPLE_W-1:0]   mean_reg;
  logic [ROOT_W-1:0]     root;
  logic [ROOT_REM_W-1:0] root_rem;

  logic                       accept;
  logic                       at_cap;
  logic                       first;
  logic signed [2*SAMPLE_W-1:0] square;
  logic        [SUM_W-1:0]    sum_mag;
  logic        [REM_W:0]      div_trial;
  logic                       div_fits;
  logic        [ROOT_REM_W+1:0] root_trial_rem;
  logic        [ROOT_REM_W+1:0] root_trial;
  logic                       root_fits;

  assign accept = sample_valid && cmd.take;
  assign at_cap = (count == CNT_W'(MAX_COUNT));
  assign first  = (count == '0);
  assign square = pend_sample * pend_sample;

  assign stat.last_pend = pend && pend_last;
  assign stat.out_free  = !result_valid || result_ready;

  // Magnitude of the running sum for the unsigned divide
  assign sum_mag = running_sum[SUM_W-1] ? $unsigned(-running_sum) : $unsigned(running_sum);

  // One restoring division step: shift in the next dividend bit, try to subtract
  assign div_trial = {div_rem, div_q[DIV_W-1]};
  assign div_fits  = (div_trial >= {1'b0, count});

  // One digit of the square root: bring down two bits, test root*4+1
  assign root_trial_rem = {root_rem, div_q[DIV_W-1 -: 2]};
  assign root_trial     = {2'b00, root, 2'b01};
  assign root_fits      = (root_trial_rem >= root_trial);

  // Register the accepted item for the accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_sample <= sample;
      pend_last   <= last;
    end
  end

  // Accumulate the pending item, drop it beyond capacity, clear on finish
  always_ff @(posedge clk) begin
    if (rst || cmd.op == OP_FINISH) begin
      count               <= '0;
      running_sum         <= '0;
      running_sum_squares <= '0;
      best_max_pos        <= '0;
      best_min_pos        <= '0;
      overflow_seen       <= 1'b0;
    end else if (pend) begin
      if (at_cap) begin
        overflow_seen <= 1'b1;
      end else begin
        count               <= count + 1'b1;
        running_sum         <= running_sum + SUM_W'(pend_sample);
        running_sum_squares <= running_sum_squares + SQ_W'($unsigned(square));
        if (first || pend_sample > best_max) begin
          best_max_pos <= count[POS_W-1:0];
        end
        if (first || pend_sample < best_min) begin
          best_min_pos <= count[POS_W-1:0];
        end
      end
    end
  end

  // Extreme values need no reset: the first sample always writes them
  always_ff @(posedge clk) begin
    if (pend && !at_cap) begin
      if (first || pend_sample > best_max) begin
        best_max <= pend_sample;
      end
      if (first || pend_sample < best_min) begin
        best_min <= pend_sample;
      end
    end
  end

  // Run the mean divide, the mean product, the variance divide and the root
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_NONE, OP_FINISH: begin
      end
      OP_MEAN_LOAD: begin
        div_q   <= DIV_W'(sum_mag);
        div_rem <= '0;
      end
      OP_MEAN_STEP, OP_VAR_STEP: begin
        div_q <= {div_q[DIV_W-2:0], div_fits};
        if (div_fits) begin
          div_rem <= REM_W'(div_trial - {1'b0, count});
        end else begin
          div_rem <= div_trial[REM_W-1:0];
        end
      end
      OP_MUL_LOAD: begin
        // mean * (sum + remainder) is never negative, so work on magnitudes
        mul_a    <= div_q[SAMPLE_W-1:0];
        mul_b    <= DIV_W'(sum_mag) + DIV_W'(div_rem);
        mul_acc  <= '0;
        mean_reg <= running_sum[SUM_W-1] ? SAMPLE_W'(-div_q[SAMPLE_W-1:0])
                                         : div_q[SAMPLE_W-1:0];
      end
      OP_MUL_STEP: begin
        if (mul_a[0]) begin
          mul_acc <= mul_acc + mul_b;
        end
        mul_a <= mul_a >> 1;
        mul_b <= mul_b << 1;
      end
      OP_VAR_LOAD: begin
        div_q   <= DIV_W'(running_sum_squares) - mul_acc;
        div_rem <= '0;
      end
      OP_ROOT_LOAD: begin
        root     <= '0;
        root_rem <= '0;
      end
      OP_ROOT_STEP: begin
        div_q <= div_q << 2;
        if (root_fits) begin
          root_rem <= ROOT_REM_W'(root_trial_rem - root_trial);
          root     <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          root_rem <= root_trial_rem[ROOT_REM_W-1:0];
          root     <= {root[ROOT_W-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.op == OP_FINISH) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FINISH) begin
      mean_value   <= mean_reg;
      std_dev      <= root[SAMPLE_W-1:0];
      max_value    <= best_max;
      max_position <= best_max_pos;
      min_value    <= best_min;
      min_position <= best_min_pos;
      sample_count <= count;
      overflow     <= overflow_seen;
    end
  end

endmodule

`default_nettype wire
